### sv/steady_state_kalman_update_unit_assert.svh
// ----------------------------------------------------------------------------
// Kalman update unit assertion macros
// Shared property forms for the update unit checks.
// ----------------------------------------------------------------------------
`ifndef STEADY_STATE_KALMAN_UPDATE_UNIT_ASSERT_SVH
`define STEADY_STATE_KALMAN_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define SSKU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSKU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ssku_pkg.sv
// ----------------------------------------------------------------------------
// Kalman update unit package
// Types, constants and helpers shared by the update unit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ssku_pkg;

  localparam int STATE_COUNT   = 15;
  localparam int MEASURE_COUNT = 12;
  localparam int COMMAND_COUNT = 4;
  localparam int TERM_COUNT    = STATE_COUNT + COMMAND_COUNT + MEASURE_COUNT;

  localparam int COEF_B_BASE = STATE_COUNT * STATE_COUNT;
  localparam int COEF_K_BASE = COEF_B_BASE + STATE_COUNT * COMMAND_COUNT;
  localparam int COEF_DEPTH  = COEF_K_BASE + STATE_COUNT * MEASURE_COUNT;
  localparam int COEF_AW     = $clog2(COEF_DEPTH);

  localparam int OPND_W = 33;
  localparam int PROD_W = 2 * OPND_W;
  localparam int ACC_W  = 72;
  localparam int RND_W  = ACC_W - 16;
  localparam int SUM_W  = 58;

  localparam logic [30:0] GRAVITY_RESET = 31'd642908;
  localparam logic [16:0] ONE_Q16       = 17'd65536;

  localparam logic [2:0] ACT_LOAD_A   = 3'd0;
  localparam logic [2:0] ACT_LOAD_B   = 3'd1;
  localparam logic [2:0] ACT_LOAD_K   = 3'd2;
  localparam logic [2:0] ACT_LOAD_M   = 3'd3;
  localparam logic [2:0] ACT_LOAD_C   = 3'd4;
  localparam logic [2:0] ACT_UPDATE   = 3'd5;
  localparam logic [2:0] ACT_CLEAR    = 3'd6;

  localparam logic [1:0] CFG_GRAVITY  = 2'd0;
  localparam logic [1:0] CFG_MASS     = 2'd1;
  localparam logic [1:0] CFG_POLE     = 2'd2;

  localparam logic [2:0] KIND_GX4  = 3'd0;
  localparam logic [2:0] KIND_GX3  = 3'd1;
  localparam logic [2:0] KIND_MG   = 3'd2;
  localparam logic [2:0] KIND_ROW  = 3'd3;
  localparam logic [2:0] KIND_FILT = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         estimate_index;
    logic signed [31:0] estimate_value;
    logic               saturated;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic [2:0] kind;
    logic [3:0] idx;
  } mac_tag_t;

  // {clip, value}
  function automatic logic [32:0] sat32c(input logic signed [SUM_W-1:0] v);
    logic [32:0] r;
    if (v > $signed({{(SUM_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < $signed({{(SUM_W-32){1'b1}}, 32'h8000_0000})) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/ssku_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssku_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/ssku_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered product, exact wide accumulate, round half up and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssku_mac (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            op_vld,
  input  wire ssku_pkg::mac_tag_t              op_tag,
  input  wire logic signed [ssku_pkg::OPND_W-1:0] op_a,
  input  wire logic signed [ssku_pkg::OPND_W-1:0] op_b,
  output logic                                 fin_vld,
  output ssku_pkg::mac_tag_t                   fin_tag,
  output logic signed [ssku_pkg::RND_W-1:0]    fin_round,
  output logic signed [31:0]                   fin_value,
  output logic                                 fin_clip
);
  import ssku_pkg::*;

  logic signed [PROD_W-1:0] p_r;
  logic                     p_vld_r;
  mac_tag_t                 p_tag_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     fin_vld_r;
  mac_tag_t                 fin_tag_r;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic [32:0]              sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      fin_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= op_vld;
      fin_vld_r <= p_vld_r & p_tag_r.last;
    end
    p_r <= op_a * op_b;
    if (op_vld) begin
      p_tag_r <= op_tag;
    end
    if (p_vld_r) begin
      acc_r     <= acc_base + ACC_W'(p_r);
      fin_tag_r <= p_tag_r;
    end
  end

  always_comb begin
    acc_base  = p_tag_r.first ? '0 : acc_r;
    acc_rnd   = acc_r + ACC_W'(32768);
    fin_round = acc_rnd[ACC_W-1:16];
    sat       = sat32c(SUM_W'(fin_round));
    fin_value = sat[31:0];
    fin_clip  = sat[32];
  end

  assign fin_vld = fin_vld_r;
  assign fin_tag = fin_tag_r;

endmodule
`default_nettype wire

### sv/steady_state_kalman_update_unit.sv
// ----------------------------------------------------------------------------
// Steady-state Kalman update unit
// Fixed-gain observer, 15 states, 12 measurements, 4 commands, Q16.16.
//
// Input channel in_valid/in_stall carries requests: coefficient loads,
// measurement and command loads, clear and update. An update runs on
// one shared multiply-accumulate unit: 3 gravity products, an innovation
// step, 465 row terms and 8 command filter terms, all limited by the
// single multiplier and the one coefficient RAM read port.
// It then emits 15 estimates on out_valid/out_stall, one per cycle when
// the receiver does not stall; a stall holds the current estimate.
// in_stall stays high from the update request until the last estimate
// is taken. Configuration writes on cfg_we are taken in any cycle.
// Reset clears estimates, filtered commands and registers to their
// defaults; coefficient and buffer contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module steady_state_kalman_update_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ssku_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ssku_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import ssku_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE   = 3'd1;
  localparam logic [2:0] ST_PWAIT = 3'd2;
  localparam logic [2:0] ST_INNOV = 3'd3;
  localparam logic [2:0] ST_ROWS  = 3'd4;
  localparam logic [2:0] ST_FILT  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]         state_r;
  logic [30:0]        gravity_r;
  logic signed [31:0] mass_r;
  logic [16:0]        pole_r;

  logic signed [31:0] x_r [STATE_COUNT];
  logic               xclip_r [STATE_COUNT];
  logic signed [31:0] next_r [STATE_COUNT];
  logic               nclip_r [STATE_COUNT];
  logic signed [31:0] f_r [COMMAND_COUNT];
  logic signed [31:0] m_r [MEASURE_COUNT];
  logic signed [31:0] c_r [COMMAND_COUNT];
  logic signed [31:0] e_r [MEASURE_COUNT];
  logic signed [31:0] v0_r;
  logic signed [RND_W-1:0] r_gx4_r, r_gx3_r, r_mg_r;

  logic [3:0]         row_r;
  logic [4:0]         term_r;
  logic [3:0]         out_cnt_r;
  logic [COEF_AW-1:0] abase_r, bbase_r, kbase_r;

  logic                     iss_vld, iss_vld_r;
  mac_tag_t                 iss_tag, iss_tag_r;
  logic                     iss_ram, iss_ram_r;
  logic signed [OPND_W-1:0] iss_a, iss_a_r, iss_b, iss_b_r;
  logic [COEF_AW-1:0]       raddr;
  logic [31:0]              rdata;
  logic signed [OPND_W-1:0] mac_a;

  logic                     fin_vld;
  mac_tag_t                 fin_tag;
  logic signed [RND_W-1:0]  fin_round;
  logic signed [31:0]       fin_value;
  logic                     fin_clip;

  logic               in_acc, out_acc;
  logic               we;
  logic [COEF_AW-1:0] waddr;
  logic [16:0]        pole_eff, comp;
  logic [1:0]         fidx;
  logic [4:0]         kterm;
  logic signed [SUM_W-1:0] y9s, y10s;
  logic [32:0]        y9c, y10c;
  logic signed [31:0] y [MEASURE_COUNT];
  logic signed [31:0] e_nxt [MEASURE_COUNT];
  logic [32:0]        e_c [MEASURE_COUNT];
  logic [32:0]        v0c;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_acc  = out_valid & ~out_stall;

  assign pole_eff = (pole_r > ONE_Q16) ? ONE_Q16 : pole_r;
  assign comp     = ONE_Q16 - pole_eff;
  assign fidx     = term_r[2:1];
  assign kterm    = term_r - 5'(STATE_COUNT + COMMAND_COUNT);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    if (in_acc) begin
      case (in_data.action)
        ACT_LOAD_A: begin
          we    = (in_data.row < 4'(STATE_COUNT)) && (in_data.col < 4'(STATE_COUNT));
          waddr = COEF_AW'(in_data.row) * COEF_AW'(STATE_COUNT) + COEF_AW'(in_data.col);
        end
        ACT_LOAD_B: begin
          we    = (in_data.row < 4'(STATE_COUNT)) && (in_data.col < 4'(COMMAND_COUNT));
          waddr = COEF_AW'(COEF_B_BASE) + COEF_AW'(in_data.row) * COEF_AW'(COMMAND_COUNT)
                  + COEF_AW'(in_data.col);
        end
        ACT_LOAD_K: begin
          we    = (in_data.row < 4'(STATE_COUNT)) && (in_data.col < 4'(MEASURE_COUNT));
          waddr = COEF_AW'(COEF_K_BASE) + COEF_AW'(in_data.row) * COEF_AW'(MEASURE_COUNT)
                  + COEF_AW'(in_data.col);
        end
        default: begin
          we    = 1'b0;
          waddr = '0;
        end
      endcase
    end
  end

  ssku_ram #(
    .WIDTH (32),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_data.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // issue stage
  always_comb begin
    iss_vld = 1'b0;
    iss_tag = '0;
    iss_ram = 1'b0;
    iss_a   = '0;
    iss_b   = '0;
    raddr   = '0;
    case (state_r)
      ST_PRE: begin
        iss_vld       = 1'b1;
        iss_tag.first = 1'b1;
        iss_tag.last  = 1'b1;
        iss_a         = OPND_W'({1'b0, gravity_r});
        case (term_r[1:0])
          2'd0: begin
            iss_tag.kind = KIND_GX4;
            iss_b        = OPND_W'(x_r[4]);
          end
          2'd1: begin
            iss_tag.kind = KIND_GX3;
            iss_b        = OPND_W'(x_r[3]);
          end
          default: begin
            iss_tag.kind = KIND_MG;
            iss_b        = OPND_W'(mass_r);
          end
        endcase
      end
      ST_ROWS: begin
        iss_vld       = 1'b1;
        iss_ram       = 1'b1;
        iss_tag.first = (term_r == '0);
        iss_tag.last  = (term_r == 5'(TERM_COUNT - 1));
        iss_tag.kind  = KIND_ROW;
        iss_tag.idx   = row_r;
        if (term_r < 5'(STATE_COUNT)) begin
          raddr = abase_r + COEF_AW'(term_r);
          iss_b = OPND_W'(x_r[term_r[3:0]]);
        end else if (term_r < 5'(STATE_COUNT + COMMAND_COUNT)) begin
          raddr = bbase_r + COEF_AW'(term_r - 5'(STATE_COUNT));
          iss_b = OPND_W'(f_r[2'(term_r - 5'(STATE_COUNT))]);
        end else begin
          raddr = kbase_r + COEF_AW'(kterm);
          iss_b = OPND_W'(e_r[kterm[3:0]]);
        end
      end
      ST_FILT: begin
        iss_vld       = 1'b1;
        iss_tag.first = ~term_r[0];
        iss_tag.last  = term_r[0];
        iss_tag.kind  = KIND_FILT;
        iss_tag.idx   = 4'(fidx);
        if (!term_r[0]) begin
          iss_a = OPND_W'({1'b0, pole_eff});
          iss_b = OPND_W'(f_r[fidx]);
        end else begin
          iss_a = OPND_W'({1'b0, comp});
          iss_b = (fidx == 2'd0) ? OPND_W'(v0_r) : OPND_W'(c_r[fidx]);
        end
      end
      default: begin
        iss_vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_vld_r <= 1'b0;
    end else begin
      iss_vld_r <= iss_vld;
    end
    iss_tag_r <= iss_tag;
    iss_ram_r <= iss_ram;
    iss_a_r   <= iss_a;
    iss_b_r   <= iss_b;
  end

  assign mac_a = iss_ram_r ? OPND_W'($signed(rdata)) : iss_a_r;

  ssku_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_vld    (iss_vld_r),
    .op_tag    (iss_tag_r),
    .op_a      (mac_a),
    .op_b      (iss_b_r),
    .fin_vld   (fin_vld),
    .fin_tag   (fin_tag),
    .fin_round (fin_round),
    .fin_value (fin_value),
    .fin_clip  (fin_clip)
  );

  // innovation
  always_comb begin
    y9s  = SUM_W'(x_r[12]) - SUM_W'(r_gx4_r);
    y10s = SUM_W'(x_r[13]) + SUM_W'(r_gx3_r);
    y9c  = sat32c(y9s);
    y10c = sat32c(y10s);
    for (int i = 0; i < 6; i++) begin
      y[i] = x_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      y[i+6] = x_r[i+9];
    end
    y[9]  = y9c[31:0];
    y[10] = y10c[31:0];
    y[11] = x_r[14];
    for (int i = 0; i < MEASURE_COUNT - 1; i++) begin
      e_c[i]   = sat32c(SUM_W'(m_r[i]) - SUM_W'(y[i]));
      e_nxt[i] = e_c[i][31:0];
    end
    e_c[MEASURE_COUNT-1] = sat32c(SUM_W'(m_r[MEASURE_COUNT-1])
                                  - SUM_W'({1'b0, gravity_r})
                                  - SUM_W'(y[MEASURE_COUNT-1]));
    e_nxt[MEASURE_COUNT-1] = e_c[MEASURE_COUNT-1][31:0];
    v0c = sat32c(SUM_W'(c_r[0]) - SUM_W'(r_mg_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      gravity_r <= GRAVITY_RESET;
      mass_r    <= '0;
      pole_r    <= '0;
      row_r     <= '0;
      term_r    <= '0;
      out_cnt_r <= '0;
      for (int i = 0; i < STATE_COUNT; i++) begin
        x_r[i]     <= '0;
        xclip_r[i] <= 1'b0;
      end
      for (int i = 0; i < COMMAND_COUNT; i++) begin
        f_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRAVITY: gravity_r <= cfg_data[30:0];
          CFG_MASS:    mass_r    <= cfg_data;
          CFG_POLE:    pole_r    <= cfg_data[16:0];
          default:     ;
        endcase
      end
      if (fin_vld && fin_tag.kind == KIND_FILT) begin
        f_r[fin_tag.idx[1:0]] <= fin_value;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_data.action)
              ACT_LOAD_M: begin
                if (in_data.row < 4'(MEASURE_COUNT)) begin
                  m_r[in_data.row] <= in_data.value;
                end
              end
              ACT_LOAD_C: begin
                if (in_data.row < 4'(COMMAND_COUNT)) begin
                  c_r[in_data.row[1:0]] <= in_data.value;
                end
              end
              ACT_CLEAR: begin
                for (int i = 0; i < STATE_COUNT; i++) begin
                  x_r[i] <= '0;
                end
                for (int i = 0; i < COMMAND_COUNT; i++) begin
                  f_r[i] <= '0;
                end
              end
              ACT_UPDATE: begin
                state_r <= ST_PRE;
                term_r  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_PRE: begin
          term_r <= term_r + 5'd1;
          if (term_r == 5'd2) begin
            state_r <= ST_PWAIT;
          end
        end
        ST_PWAIT: begin
          if (fin_vld && fin_tag.kind == KIND_MG) begin
            state_r <= ST_INNOV;
          end
        end
        ST_INNOV: begin
          for (int i = 0; i < MEASURE_COUNT; i++) begin
            e_r[i] <= e_nxt[i];
          end
          v0_r    <= v0c[31:0];
          row_r   <= '0;
          term_r  <= '0;
          abase_r <= '0;
          bbase_r <= COEF_AW'(COEF_B_BASE);
          kbase_r <= COEF_AW'(COEF_K_BASE);
          state_r <= ST_ROWS;
        end
        ST_ROWS: begin
          if (term_r == 5'(TERM_COUNT - 1)) begin
            term_r  <= '0;
            row_r   <= row_r + 4'd1;
            abase_r <= abase_r + COEF_AW'(STATE_COUNT);
            bbase_r <= bbase_r + COEF_AW'(COMMAND_COUNT);
            kbase_r <= kbase_r + COEF_AW'(MEASURE_COUNT);
            if (row_r == 4'(STATE_COUNT - 1)) begin
              state_r <= ST_FILT;
            end
          end else begin
            term_r <= term_r + 5'd1;
          end
        end
        ST_FILT: begin
          term_r <= term_r + 5'd1;
          if (term_r == 5'(2 * COMMAND_COUNT - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (fin_vld && fin_tag.kind == KIND_FILT
              && fin_tag.idx == 4'(COMMAND_COUNT - 1)) begin
            for (int i = 0; i < STATE_COUNT; i++) begin
              x_r[i]     <= next_r[i];
              xclip_r[i] <= nclip_r[i];
            end
            out_cnt_r <= '0;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            out_cnt_r <= out_cnt_r + 4'd1;
            if (out_cnt_r == 4'(STATE_COUNT - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // hold rounded gravity terms and finished rows
  always_ff @(posedge clk) begin
    if (fin_vld) begin
      case (fin_tag.kind)
        KIND_GX4: r_gx4_r <= fin_round;
        KIND_GX3: r_gx3_r <= fin_round;
        KIND_MG:  r_mg_r  <= fin_round;
        KIND_ROW: begin
          next_r[fin_tag.idx]  <= fin_value;
          nclip_r[fin_tag.idx] <= fin_clip;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data.estimate_index = out_cnt_r;
    out_data.estimate_value = x_r[out_cnt_r];
    out_data.saturated      = xclip_r[out_cnt_r];
    out_data.last           = (out_cnt_r == 4'(STATE_COUNT - 1));
  end

`include "steady_state_kalman_update_unit_assert.svh"

  `SSKU_ASSERT_IMPL(a_out_blocks_in, out_valid, in_stall, "input taken while emitting")
  `SSKU_ASSERT_NEXT(a_last_ends_run, out_acc && out_data.last, !out_valid,
                    "estimates continue past last")
  `SSKU_ASSERT_IMPL(a_row_fin_in_run, fin_vld && fin_tag.kind == KIND_ROW,
                    state_r == ST_ROWS || state_r == ST_FILT || state_r == ST_DRAIN,
                    "row sum finished outside an update")

endmodule
`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Kalman update unit testbench
// Loads coefficients, measurements and commands, runs updates and compares
// every emitted estimate with a bit-exact fixed-point predictor. Both sides
// insert random gaps; one long receiver hold-off and drain pauses between batches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import ssku_pkg::*;

  localparam logic [2:0] ACT_RESERVED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  steady_state_kalman_update_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint est_q[STATE_COUNT];
  longint filt_q[COMMAND_COUNT];
  longint a_mat[STATE_COUNT*STATE_COUNT];
  longint b_mat[STATE_COUNT*COMMAND_COUNT];
  longint k_mat[STATE_COUNT*MEASURE_COUNT];
  longint meas_q[MEASURE_COUNT];
  longint cmd_q[COMMAND_COUNT];
  longint grav_r, mass_r, pole_r;

  in_item_t request_q[$];
  out_item_t estimate_q[$];
  int errors = 0;
  int updates_seen = 0;
  int estimates_seen = 0;
  int hold_cycles = 0;
  bit feeding = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic longint sat32(longint v, output bit clip);
    clip = 1'b0;
    if (v > 64'sd2147483647) begin clip = 1'b1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin clip = 1'b1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint rnd16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  task automatic predict_update();
    longint y[MEASURE_COUNT];
    longint e[MEASURE_COUNT];
    longint nxt[STATE_COUNT];
    bit clp[STATE_COUNT];
    bit dc;
    logic signed [95:0] acc;
    longint pole, comp, v;
    out_item_t o;
    for (int i = 0; i < 3; i++) begin
      y[i] = est_q[i]; y[i+3] = est_q[i+3]; y[i+6] = est_q[i+9];
    end
    y[9] = sat32(est_q[12] - rnd16(grav_r * est_q[4]), dc);
    y[10] = sat32(est_q[13] + rnd16(grav_r * est_q[3]), dc);
    y[11] = est_q[14];
    for (int i = 0; i < MEASURE_COUNT - 1; i++) e[i] = sat32(meas_q[i] - y[i], dc);
    e[11] = sat32(meas_q[11] - grav_r - y[11], dc);
    for (int i = 0; i < STATE_COUNT; i++) begin
      acc = 0;
      for (int j = 0; j < STATE_COUNT; j++)
        acc += 96'(a_mat[i*STATE_COUNT+j] * est_q[j]);
      for (int j = 0; j < COMMAND_COUNT; j++)
        acc += 96'(b_mat[i*COMMAND_COUNT+j] * filt_q[j]);
      for (int j = 0; j < MEASURE_COUNT; j++)
        acc += 96'(k_mat[i*MEASURE_COUNT+j] * e[j]);
      acc = (acc + 96'sd32768) >>> 16;
      if (acc > 96'sd2147483647) begin nxt[i] = 64'sd2147483647; clp[i] = 1'b1; end
      else if (acc < -96'sd2147483648) begin nxt[i] = -64'sd2147483648; clp[i] = 1'b1; end
      else begin nxt[i] = longint'(acc); clp[i] = 1'b0; end
    end
    for (int i = 0; i < STATE_COUNT; i++) est_q[i] = nxt[i];
    pole = (pole_r > 65536) ? 65536 : pole_r;
    comp = 65536 - pole;
    for (int i = 0; i < COMMAND_COUNT; i++) begin
      v = cmd_q[i];
      if (i == 0) v = sat32(v - rnd16(mass_r * grav_r), dc);
      filt_q[i] = sat32(rnd16(pole * filt_q[i] + comp * v), dc);
    end
    for (int i = 0; i < STATE_COUNT; i++) begin
      o.estimate_index = 4'(i);
      o.estimate_value = 32'(nxt[i]);
      o.saturated = clp[i];
      o.last = (i == STATE_COUNT - 1);
      estimate_q.push_back(o);
    end
  endtask

  task automatic apply_request(in_item_t r);
    longint v;
    v = longint'(r.value);
    case (r.action)
      ACT_LOAD_A: if (r.row < STATE_COUNT && r.col < STATE_COUNT)
        a_mat[r.row*STATE_COUNT+r.col] = v;
      ACT_LOAD_B: if (r.row < STATE_COUNT && r.col < COMMAND_COUNT)
        b_mat[r.row*COMMAND_COUNT+r.col] = v;
      ACT_LOAD_K: if (r.row < STATE_COUNT && r.col < MEASURE_COUNT)
        k_mat[r.row*MEASURE_COUNT+r.col] = v;
      ACT_LOAD_M: if (r.row < MEASURE_COUNT) meas_q[r.row] = v;
      ACT_LOAD_C: if (r.row < COMMAND_COUNT) cmd_q[r.row] = v;
      ACT_UPDATE: begin
        updates_seen++;
        predict_update();
      end
      ACT_CLEAR: begin
        foreach (est_q[i]) est_q[i] = 0;
        foreach (filt_q[i]) filt_q[i] = 0;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_request(in_data);
        void'(request_q.pop_front());
        in_gap = $urandom_range(0, 5);
        if (feeding && request_q.size() > 0 && in_gap == 0) begin
          in_data <= request_q[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && feeding && request_q.size() > 0) begin
        if (in_gap > 0) in_gap--;
        else begin
          in_data <= request_q[0];
          in_valid <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        estimates_seen++;
        if (estimate_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected estimate %h", $time, out_data);
        end else begin
          if (out_data !== estimate_q[0]) begin
            errors++;
            $display("%0t: mismatch expected idx=%0d val=%h sat=%b last=%b,",
                     $time, estimate_q[0].estimate_index, estimate_q[0].estimate_value,
                     estimate_q[0].saturated, estimate_q[0].last);
            $display("  actual idx=%0d val=%h sat=%b last=%b", out_data.estimate_index,
                     out_data.estimate_value, out_data.saturated, out_data.last);
          end
          void'(estimate_q.pop_front());
        end
        out_gap = $urandom_range(0, 5);
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  function automatic in_item_t mk(logic [2:0] act, int r, int c, logic [31:0] v);
    in_item_t t;
    t.action = act; t.row = 4'(r); t.col = 4'(c); t.value = v;
    return t;
  endfunction

  function automatic logic [31:0] rand_val(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return 32'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic drain();
    while (request_q.size() > 0 || estimate_q.size() > 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRAVITY: grav_r = longint'(d[30:0]);
      CFG_MASS: mass_r = longint'($signed(d));
      default: pole_r = longint'(d[16:0]);
    endcase
  endtask

  // full well-formed data set, small or random magnitudes
  task automatic queue_all_loads(int mode);
    for (int r = 0; r < STATE_COUNT; r++)
      for (int c = 0; c < STATE_COUNT; c++)
        request_q.push_back(mk(ACT_LOAD_A, r, c, rand_val(mode)));
    for (int r = 0; r < STATE_COUNT; r++)
      for (int c = 0; c < COMMAND_COUNT; c++)
        request_q.push_back(mk(ACT_LOAD_B, r, c, rand_val(mode)));
    for (int r = 0; r < STATE_COUNT; r++)
      for (int c = 0; c < MEASURE_COUNT; c++)
        request_q.push_back(mk(ACT_LOAD_K, r, c, rand_val(mode)));
    for (int r = 0; r < MEASURE_COUNT; r++)
      request_q.push_back(mk(ACT_LOAD_M, r, 0, rand_val(mode)));
    for (int r = 0; r < COMMAND_COUNT; r++)
      request_q.push_back(mk(ACT_LOAD_C, r, 0, rand_val(mode)));
  endtask

  task automatic queue_random(int n);
    int a;
    int r;
    int c;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      a = $urandom_range(0, 9);
      r = $urandom_range(0, 15);
      c = $urandom_range(0, 15);
      v = rand_val($urandom_range(0, 2));
      case (a)
        0: request_q.push_back(mk(ACT_LOAD_A, r, c, v));
        1: request_q.push_back(mk(ACT_LOAD_B, r, c, v));
        2: request_q.push_back(mk(ACT_LOAD_K, r, c, v));
        3: request_q.push_back(mk(ACT_LOAD_M, r, c, v));
        4: request_q.push_back(mk(ACT_LOAD_C, r, c, v));
        5, 6, 7: request_q.push_back(mk(ACT_UPDATE, r, c, $urandom()));
        8: request_q.push_back(mk(ACT_CLEAR, r, c, $urandom()));
        default: request_q.push_back(mk(ACT_RESERVED, r, c, $urandom()));
      endcase
    end
  endtask

  initial begin
    foreach (est_q[i]) est_q[i] = 0;
    foreach (filt_q[i]) filt_q[i] = 0;
    grav_r = GRAVITY_RESET; mass_r = 0; pole_r = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    feeding = 1'b1;

    // directed: extremes, saturation, ignored loads, unused code, clear
    queue_all_loads(2);
    request_q.push_back(mk(ACT_LOAD_A, 15, 0, 32'h7FFF_FFFF));
    request_q.push_back(mk(ACT_LOAD_B, 0, 4, 32'h8000_0000));
    request_q.push_back(mk(ACT_LOAD_K, 0, 12, 32'h7FFF_FFFF));
    request_q.push_back(mk(ACT_LOAD_M, 12, 0, 32'h8000_0000));
    request_q.push_back(mk(ACT_LOAD_C, 4, 15, 32'hFFFF_FFFF));
    request_q.push_back(mk(ACT_RESERVED, 15, 15, 32'hFFFF_FFFF));
    request_q.push_back(mk(ACT_UPDATE, 0, 0, 0));
    request_q.push_back(mk(ACT_LOAD_A, 0, 0, 32'h7FFF_FFFF));
    request_q.push_back(mk(ACT_LOAD_K, 14, 11, 32'h8000_0000));
    request_q.push_back(mk(ACT_LOAD_M, 11, 0, 32'h7FFF_FFFF));
    request_q.push_back(mk(ACT_UPDATE, 15, 15, 32'hFFFF_FFFF));
    request_q.push_back(mk(ACT_UPDATE, 0, 0, 0));
    request_q.push_back(mk(ACT_CLEAR, 0, 0, 0));
    request_q.push_back(mk(ACT_UPDATE, 0, 0, 0));
    drain();

    write_cfg(CFG_GRAVITY, 32'h7FFF_FFFF);
    write_cfg(CFG_MASS, 32'h8000_0000);
    write_cfg(CFG_POLE, 32'h0001_FFFF);
    request_q.push_back(mk(ACT_UPDATE, 0, 0, 0));
    request_q.push_back(mk(ACT_UPDATE, 0, 0, 0));
    // receiver holds off while updates queue up behind the stalled input
    hold_cycles = 3000;
    request_q.push_back(mk(ACT_LOAD_M, 0, 0, 0));
    request_q.push_back(mk(ACT_UPDATE, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_GRAVITY, (ph == 0) ? 32'h0 : $urandom());
      write_cfg(CFG_MASS, (ph == 1) ? 32'h7FFF_FFFF : $urandom());
      write_cfg(CFG_POLE, (ph == 2) ? 32'h0001_0000 : $urandom_range(0, 65536));
      queue_random(20);
      drain();
    end

    $display("run covered %0d updates and %0d estimates over several register settings,",
             updates_seen, estimates_seen);
    $display("with random gaps, a long receiver hold-off and extreme coefficients");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end
endmodule
